// ===== design/fsp_pkg.sv =====
`timescale 1ns / 1ps

package fsp_pkg;

    // default sizes
    localparam int NEEDLE_MAX_DEF    = 16;
    localparam int POSITION_BITS_DEF = 16;

    // needle bytes held in the two 64-bit registers
    localparam int NEEDLE_REG_BYTES  = 16;
    localparam int NEEDLE_IDX_W      = 7;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 64;
    localparam int LENGTH_W          = 5;
    localparam int POS_FIELD_W       = 16;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NEEDLE_LOW  = 2'd0,
        REG_NEEDLE_HIGH = 2'd1,
        REG_NEEDLE_LEN  = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_index_t;

    typedef logic [NEEDLE_REG_BYTES-1:0][7:0] needle_t;

    typedef struct packed {
        logic [7:0] haystack_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic                   found;
        logic [POS_FIELD_W-1:0] position;
        logic                   overflow;
    } out_item_t;

    // needle byte at index idx, zero beyond the registers
    function automatic logic [7:0] needle_byte(input needle_t needle,
                                               input logic [NEEDLE_IDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'd0;
        if (idx < NEEDLE_IDX_W'(NEEDLE_REG_BYTES))
        begin
            b = needle[idx[3:0]];
        end
        return b;
    endfunction

endpackage

// ===== design/fsp_cell.sv =====
`timescale 1ns / 1ps

module fsp_cell #(
    parameter int K          = 0,
    parameter int NEEDLE_MAX = fsp_pkg::NEEDLE_MAX_DEF,
    parameter bit HAS_REG    = 1'b1,
    localparam int LEN_W     = $clog2(NEEDLE_MAX + 1)
) (
    input  logic             clk,
    input  logic             shift,
    input  logic [7:0]       win_byte,
    input  fsp_pkg::needle_t needle,
    input  logic [LEN_W-1:0] len,
    input  logic             chain_in,
    output logic             chain_out,
    output logic [7:0]       stored_byte
);

    logic in_use;
    logic eq;

    // this window slot lines up with needle byte len-1-K
    assign in_use = fsp_pkg::NEEDLE_IDX_W'(K) < fsp_pkg::NEEDLE_IDX_W'(len);
    assign eq = !in_use ||
                (win_byte == fsp_pkg::needle_byte(needle,
                    fsp_pkg::NEEDLE_IDX_W'(len) - fsp_pkg::NEEDLE_IDX_W'(K)
                    - fsp_pkg::NEEDLE_IDX_W'(1)));

    // running match flag handed down the row
    assign chain_out = chain_in && eq;

    // window byte moves to the next slot on each transfer
    generate
        if (HAS_REG)
        begin : g_reg
            logic [7:0] byte_reg;
            always_ff @(posedge clk)
            begin
                if (shift)
                begin
                    byte_reg <= win_byte;
                end
            end
            assign stored_byte = byte_reg;
        end
        else
        begin : g_noreg
            assign stored_byte = 8'd0;
        end
    endgenerate

endmodule

// ===== design/first_substring_position.sv =====
`timescale 1ns / 1ps
// The result for a haystack is offered in the cycle after its last byte transfers.
// Throughput: one haystack byte per cycle unless the output stalls; the window
// compare runs in one NEEDLE_MAX cell row, match flags ANDed along it in the same cycle.
// Reset (async, active low) clears the needle registers, counters, match state and
// output valid; window bytes are not reset, stale ones are masked by the byte count.

module first_substring_position #(
    parameter int NEEDLE_MAX    = fsp_pkg::NEEDLE_MAX_DEF,
    parameter int POSITION_BITS = fsp_pkg::POSITION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  fsp_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output fsp_pkg::out_item_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fsp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int LEN_W = $clog2(NEEDLE_MAX + 1);
    localparam int CLIP_W = (LEN_W > fsp_pkg::LENGTH_W) ? LEN_W : fsp_pkg::LENGTH_W;
    localparam int CMP_W = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;

    // configuration registers
    logic [fsp_pkg::CFG_DATA_W-1:0] needle_low_reg;
    logic [fsp_pkg::CFG_DATA_W-1:0] needle_high_reg;
    logic [fsp_pkg::LENGTH_W-1:0]   needle_len_reg;

    // search state
    logic [POSITION_BITS-1:0] bytes_seen_reg, bytes_seen_next;
    logic                     match_seen_reg, match_seen_next;
    logic [POSITION_BITS-1:0] match_start_reg, match_start_next;
    logic                     overflow_reg, overflow_next;

    logic                     out_valid_reg;
    fsp_pkg::out_item_t       out_data_reg;

    fsp_pkg::needle_t         needle;
    logic [LEN_W-1:0]         len;
    logic                     in_xfer;
    logic                     counted;
    logic [POSITION_BITS-1:0] count_inc;
    logic                     full_match;

    logic [7:0]               win   [NEEDLE_MAX];
    logic                     chain [NEEDLE_MAX+1];

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign needle = {needle_high_reg, needle_low_reg};

    // needle length clipped to the row size
    assign len = (CLIP_W'(needle_len_reg) > CLIP_W'(NEEDLE_MAX)) ?
                 LEN_W'(NEEDLE_MAX) : LEN_W'(needle_len_reg);

    // row of compare cells, window slot 0 is the incoming byte
    assign win[0] = in_data.haystack_byte;
    assign chain[NEEDLE_MAX] = 1'b1;

    generate
        for (genvar k = 0; k < NEEDLE_MAX; k++)
        begin : g_cell
            if (k < NEEDLE_MAX - 1)
            begin : g_mid
                fsp_cell #(
                    .K          (k),
                    .NEEDLE_MAX (NEEDLE_MAX),
                    .HAS_REG    (1'b1)
                ) u_cell (
                    .clk         (clk),
                    .shift       (in_xfer),
                    .win_byte    (win[k]),
                    .needle      (needle),
                    .len         (len),
                    .chain_in    (chain[k+1]),
                    .chain_out   (chain[k]),
                    .stored_byte (win[k+1])
                );
            end
            else
            begin : g_end
                fsp_cell #(
                    .K          (k),
                    .NEEDLE_MAX (NEEDLE_MAX),
                    .HAS_REG    (1'b0)
                ) u_cell (
                    .clk         (clk),
                    .shift       (in_xfer),
                    .win_byte    (win[k]),
                    .needle      (needle),
                    .len         (len),
                    .chain_in    (chain[k+1]),
                    .chain_out   (chain[k]),
                    .stored_byte ()
                );
            end
        end
    endgenerate

    // byte count, match capture and saturation
    always_comb
    begin
        counted          = (bytes_seen_reg != {POSITION_BITS{1'b1}});
        count_inc        = bytes_seen_reg + POSITION_BITS'(1);
        bytes_seen_next  = counted ? count_inc : bytes_seen_reg;
        overflow_next    = overflow_reg || !counted;
        full_match       = chain[0] && (CMP_W'(count_inc) >= CMP_W'(len));
        match_seen_next  = match_seen_reg;
        match_start_next = match_start_reg;
        if (counted && !match_seen_reg)
        begin
            if (len == '0)
            begin
                match_seen_next  = 1'b1;
                match_start_next = POSITION_BITS'(1);
            end
            else if (full_match)
            begin
                match_seen_next  = 1'b1;
                match_start_next = count_inc - POSITION_BITS'(len) + POSITION_BITS'(1);
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg  <= '0;
            needle_high_reg <= '0;
            needle_len_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (fsp_pkg::reg_index_t'(cfg_index))
                fsp_pkg::REG_NEEDLE_LOW:  needle_low_reg  <= cfg_data;
                fsp_pkg::REG_NEEDLE_HIGH: needle_high_reg <= cfg_data;
                fsp_pkg::REG_NEEDLE_LEN:  needle_len_reg  <= cfg_data[fsp_pkg::LENGTH_W-1:0];
                default:                  ;
            endcase
        end
    end

    // search state, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg  <= '0;
            match_seen_reg  <= 1'b0;
            match_start_reg <= '0;
            overflow_reg    <= 1'b0;
        end
        else if (in_xfer)
        begin
            if (in_data.last_byte)
            begin
                bytes_seen_reg  <= '0;
                match_seen_reg  <= 1'b0;
                match_start_reg <= '0;
                overflow_reg    <= 1'b0;
            end
            else
            begin
                bytes_seen_reg  <= bytes_seen_next;
                match_seen_reg  <= match_seen_next;
                match_start_reg <= match_start_next;
                overflow_reg    <= overflow_next;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer && in_data.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_data.last_byte)
        begin
            out_data_reg.found    <= match_seen_next;
            out_data_reg.position <= match_seen_next ?
                                     fsp_pkg::POS_FIELD_W'(match_start_next) : '0;
            out_data_reg.overflow <= overflow_next;
        end
    end

endmodule
